[design/grid_move_expander_macros.svh]
// assertion macros shared by the grid move expander checker
// no dependencies; included by files that hold concurrent assertions
`ifndef GRID_MOVE_EXPANDER_MACROS_SVH
`define GRID_MOVE_EXPANDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define GME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid move expander: same-cycle check failed");

// next-cycle implication, disabled during reset
`define GME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid move expander: next-cycle check failed");

`endif

[design/gme_pkg.sv]
// shared types, codes and constants of the grid move expander
// no dependencies; used by the front end, queue, back end and top level
package gme_pkg;

    localparam int GRID_X_MAX = 16;
    localparam int GRID_Y_MAX = 16;
    // the bitmap is always 16 x 16, so the usable extent is capped there too
    localparam int X_LIM = (GRID_X_MAX < 16) ? GRID_X_MAX : 16;
    localparam int Y_LIM = (GRID_Y_MAX < 16) ? GRID_Y_MAX : 16;

    localparam int NUM_DIRS = 8;
    localparam int Q_DEPTH = 4;

    typedef logic [3:0] t_coord;
    typedef logic [4:0] t_size;
    typedef logic [2:0] t_dir;
    typedef logic [1:0] t_delta;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;

    localparam logic [1:0] REG_DIAG   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [7:0] COST_ORTHO = 8'd100;
    localparam logic [7:0] COST_DIAG  = 8'd141;

    localparam t_delta D_ZERO  = 2'b00;
    localparam t_delta D_PLUS  = 2'b01;
    localparam t_delta D_MINUS = 2'b11;

    // order: +x, -x, +y, -y, then +x+y, +x-y, -x+y, -x-y
    localparam t_delta DIR_DX [NUM_DIRS] = '{D_PLUS, D_MINUS, D_ZERO, D_ZERO,
                                             D_PLUS, D_PLUS, D_MINUS, D_MINUS};
    localparam t_delta DIR_DY [NUM_DIRS] = '{D_ZERO, D_ZERO, D_PLUS, D_MINUS,
                                             D_PLUS, D_MINUS, D_PLUS, D_MINUS};

    typedef struct packed {
        t_coord                fx;
        t_coord                fy;
        logic [NUM_DIRS-1:0]   mask;
        logic                  is_target;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // coordinate plus a step of -1, 0 or +1; -1 from zero lands on 31
    function automatic t_size step_coord(t_coord c, t_delta d);
        step_coord = {1'b0, c} + {{3{d[1]}}, d};
    endfunction

    function automatic t_size clamp_size(t_size v, int lim);
        clamp_size = (int'(v) > lim) ? t_size'(lim) : v;
    endfunction

endpackage

[design/gme_front.sv]
// front end: accepts transactions, keeps occupancy and target, builds move masks
// depends on gme_pkg; pushes one job per expand that has any legal move
module gme_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    input  gme_pkg::t_coord      i_cell_x,
    input  gme_pkg::t_coord      i_cell_y,
    input  logic                 i_occupied_value,
    input  logic                 i_diag_en,
    input  gme_pkg::t_size       i_w_eff,
    input  gme_pkg::t_size       i_h_eff,
    input  gme_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output gme_pkg::t_job        o_push_job
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_EX_C   = 3'd2;
    localparam logic [2:0] S_EX_LO  = 3'd3;
    localparam logic [2:0] S_EX_HI  = 3'd4;

    logic [2:0]            r_state, n_state;
    gme_pkg::t_coord       r_fx, r_fy;
    logic                  r_occ;
    gme_pkg::t_coord       r_tx, r_ty;
    logic [15:0]           r_mem [16];
    logic [15:0]           r_row_valid;
    logic [15:0]           r_rd_data;
    logic                  r_rd_valid;
    logic [15:0]           r_row_c, r_row_lo;
    gme_pkg::t_coord       rd_addr;
    logic [15:0]           row_now;
    logic [15:0]           wr_row;
    logic                  wr_en;
    logic                  accept;
    logic [gme_pkg::NUM_DIRS-1:0] mask;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || i_q_stat.full;
    assign row_now    = r_rd_valid ? r_rd_data : 16'h0000;
    assign wr_en      = (r_state == S_WRITE);

    always_comb begin
        wr_row = row_now;
        wr_row[r_fx] = r_occ;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = i_cell_y;
            S_EX_C:  rd_addr = r_fy - 4'd1;
            S_EX_LO: rd_addr = r_fy + 4'd1;
            default: rd_addr = r_fy;
        endcase
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fy] <= wr_row;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_fy] <= 1'b1;
            end
            r_rd_valid <= r_row_valid[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        gme_pkg::OP_WRITE:  n_state = S_WRITE;
                        gme_pkg::OP_EXPAND: n_state = S_EX_C;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_EX_C:  n_state = S_EX_LO;
            S_EX_LO: n_state = S_EX_HI;
            S_EX_HI: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tx    <= '0;
            r_ty    <= '0;
        end else begin
            r_state <= n_state;
            if (accept && i_op == gme_pkg::OP_TARGET) begin
                r_tx <= i_cell_x;
                r_ty <= i_cell_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fx  <= i_cell_x;
            r_fy  <= i_cell_y;
            r_occ <= i_occupied_value;
        end
        if (r_state == S_EX_C) begin
            r_row_c <= row_now;
        end
        if (r_state == S_EX_LO) begin
            r_row_lo <= row_now;
        end
    end

    // rows y-1, y, y+1 are all at hand in the last expand cycle
    always_comb begin
        gme_pkg::t_size tx, ty;
        logic [15:0]    row_t;
        logic           in_range, dest_busy, corner_busy;
        mask = '0;
        for (int d = 0; d < gme_pkg::NUM_DIRS; d++) begin
            tx = gme_pkg::step_coord(r_fx, gme_pkg::DIR_DX[d]);
            ty = gme_pkg::step_coord(r_fy, gme_pkg::DIR_DY[d]);
            row_t = (gme_pkg::DIR_DY[d] == gme_pkg::D_ZERO)  ? r_row_c :
                    (gme_pkg::DIR_DY[d] == gme_pkg::D_MINUS) ? r_row_lo : row_now;
            in_range    = (tx < i_w_eff) && (ty < i_h_eff);
            dest_busy   = row_t[tx[3:0]];
            corner_busy = r_row_c[tx[3:0]] || row_t[r_fx];
            if (d >= 4) begin
                mask[d] = in_range && !dest_busy && i_diag_en && !corner_busy;
            end else begin
                mask[d] = in_range && !dest_busy;
            end
        end
    end

    assign o_push               = (r_state == S_EX_HI) && (mask != '0);
    assign o_push_job.fx        = r_fx;
    assign o_push_job.fy        = r_fy;
    assign o_push_job.mask      = mask;
    assign o_push_job.is_target = (r_fx == r_tx) && (r_fy == r_ty);

endmodule

[design/gme_queue.sv]
// short job queue between the front end and the move emitter
// depends on gme_pkg for the job type and status struct
module gme_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gme_pkg::t_job      i_push_job,
    input  logic               i_pop,
    output gme_pkg::t_job      o_pop_job,
    output gme_pkg::t_q_stat   o_stat
);

    localparam int PW = $clog2(gme_pkg::Q_DEPTH);

    gme_pkg::t_job   r_slot [gme_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_count;

    assign o_pop_job    = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == (PW+1)'(gme_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/gme_back.sv]
// back end: walks a job's move mask and emits one move per cycle unless the output stalls
// depends on gme_pkg; owns the output register of the result channel
module gme_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gme_pkg::t_q_stat   i_q_stat,
    input  gme_pkg::t_job      i_pop_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gme_pkg::t_coord    o_from_x,
    output gme_pkg::t_coord    o_from_y,
    output gme_pkg::t_coord    o_to_x,
    output gme_pkg::t_coord    o_to_y,
    output logic [7:0]         o_move_cost,
    output logic               o_target_moved,
    output logic               o_last_move
);

    logic                          r_busy;
    gme_pkg::t_job                 r_job;
    logic                          r_out_valid;
    gme_pkg::t_dir                 sel;
    logic [gme_pkg::NUM_DIRS-1:0]  remaining;
    logic                          last;
    logic                          emit;
    gme_pkg::t_size                to_x5, to_y5;

    assign o_pop       = !r_busy && !i_q_stat.empty;
    assign emit        = r_busy && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    // lowest pending direction goes first
    always_comb begin
        sel = '0;
        for (int d = gme_pkg::NUM_DIRS - 1; d >= 0; d--) begin
            if (r_job.mask[d]) begin
                sel = gme_pkg::t_dir'(d);
            end
        end
        remaining      = r_job.mask;
        remaining[sel] = 1'b0;
        last           = (remaining == '0);
    end

    assign to_x5 = gme_pkg::step_coord(r_job.fx, gme_pkg::DIR_DX[sel]);
    assign to_y5 = gme_pkg::step_coord(r_job.fy, gme_pkg::DIR_DY[sel]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_pop_job;
        end else if (emit) begin
            r_job.mask <= remaining;
        end
        if (emit) begin
            o_from_x       <= r_job.fx;
            o_from_y       <= r_job.fy;
            o_to_x         <= to_x5[3:0];
            o_to_y         <= to_y5[3:0];
            o_move_cost    <= sel[2] ? gme_pkg::COST_DIAG : gme_pkg::COST_ORTHO;
            o_target_moved <= r_job.is_target;
            o_last_move    <= last;
        end
    end

endmodule

[design/grid_move_expander.sv]
// top level of the grid move expander: configuration registers and wiring
// depends on gme_pkg, gme_front, gme_queue and gme_back
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   op, cell_x, cell_y, occupied_value
//  result    out        o_out_valid / i_out_stall from/to x,y, move_cost, target_moved,
//                                                 last_move
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// expand: three row reads in the front end through the single occupancy read port,
// then one move per unstalled cycle from the back end, up to 8 per expand
// occupancy write: read-modify-write of one row; target write: taken while idle
// reset clears the row valid bits at once, so no clearing pass is needed
// the front end stalls while busy or when the 4-entry job queue is full
module grid_move_expander (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_op,
    input  logic [3:0]      i_cell_x,
    input  logic [3:0]      i_cell_y,
    input  logic            i_occupied_value,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [3:0]      o_from_x,
    output logic [3:0]      o_from_y,
    output logic [3:0]      o_to_x,
    output logic [3:0]      o_to_y,
    output logic [7:0]      o_move_cost,
    output logic            o_target_moved,
    output logic            o_last_move,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic                r_diag_en;
    gme_pkg::t_size      r_grid_w, r_grid_h;
    gme_pkg::t_size      w_eff, h_eff;
    logic                cfg_wr;
    gme_pkg::t_q_stat    q_stat;
    logic                push, pop;
    gme_pkg::t_job       push_job, pop_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign w_eff  = gme_pkg::clamp_size(r_grid_w, gme_pkg::X_LIM);
    assign h_eff  = gme_pkg::clamp_size(r_grid_h, gme_pkg::Y_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_en <= 1'b0;
            r_grid_w  <= 5'd16;
            r_grid_h  <= 5'd16;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gme_pkg::REG_DIAG:   r_diag_en <= pwdata[0];
                gme_pkg::REG_WIDTH:  r_grid_w  <= pwdata[4:0];
                gme_pkg::REG_HEIGHT: r_grid_h  <= pwdata[4:0];
                default:             r_diag_en <= r_diag_en;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gme_pkg::REG_DIAG:   prdata = {31'd0, r_diag_en};
            gme_pkg::REG_WIDTH:  prdata = {27'd0, r_grid_w};
            gme_pkg::REG_HEIGHT: prdata = {27'd0, r_grid_h};
            default:             prdata = 32'd0;
        endcase
    end

    gme_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_occupied_value (i_occupied_value),
        .i_diag_en        (r_diag_en),
        .i_w_eff          (w_eff),
        .i_h_eff          (h_eff),
        .i_q_stat         (q_stat),
        .o_push           (push),
        .o_push_job       (push_job)
    );

    gme_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_stat     (q_stat)
    );

    gme_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_pop_job      (pop_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_from_x       (o_from_x),
        .o_from_y       (o_from_y),
        .o_to_x         (o_to_x),
        .o_to_y         (o_to_y),
        .o_move_cost    (o_move_cost),
        .o_target_moved (o_target_moved),
        .o_last_move    (o_last_move)
    );

endmodule

[design/gme_checker.sv]
// port-level checks of the grid move expander, bound to the top level
// depends on grid_move_expander_macros.svh and the top level's ports
`include "grid_move_expander_macros.svh"

module gme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_from_x,
    input logic [3:0]  o_from_y,
    input logic [3:0]  o_to_x,
    input logic [3:0]  o_to_y,
    input logic [7:0]  o_move_cost,
    input logic        o_last_move,
    input logic        pready
);

    logic is_diag_cost;
    logic is_diag_step;
    logic mid_burst;

    assign is_diag_cost = (o_move_cost == 8'd141);
    assign is_diag_step = (o_to_x != o_from_x) && (o_to_y != o_from_y);
    assign mid_burst    = o_out_valid && !i_out_stall && !o_last_move;

    // a stalled result stays valid
    `GME_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // diagonal cost exactly when both coordinates change
    `GME_ASSERT_NOW(a_cost_kind, i_clk, i_rst_n, o_out_valid, is_diag_cost == is_diag_step)

    // moves of one expand leave back to back
    `GME_ASSERT_NEXT(a_burst, i_clk, i_rst_n, mid_burst, o_out_valid)

    // the configuration port never waits
    `GME_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind grid_move_expander gme_checker u_gme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_from_x    (o_from_x),
    .o_from_y    (o_from_y),
    .o_to_x      (o_to_x),
    .o_to_y      (o_to_y),
    .o_move_cost (o_move_cost),
    .o_last_move (o_last_move),
    .pready      (pready)
);
